>>> rtl/core/wblc_pkg.sv
// Shared types and constants for the write-back LFU tag cache.
// No dependencies.
`timescale 1ns / 1ps
package wblc_pkg;
    localparam int ENTRIES_DEF    = 8;
    localparam int VALUE_BITS_DEF = 64;
    localparam int OWNER_BITS_DEF = 32;
    localparam int KEY_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [1:0] OP_READ      = 2'd0;
    localparam logic [1:0] OP_WRITE     = 2'd1;
    localparam logic [1:0] OP_FLUSH_OWN = 2'd2;
    localparam logic [1:0] OP_FLUSH_ALL = 2'd3;

    localparam logic [2:0] K_WRITEBACK = 3'd0;
    localparam logic [2:0] K_READ_DATA = 3'd1;
    localparam logic [2:0] K_WRITE_THR = 3'd2;
    localparam logic [2:0] K_DONE      = 3'd3;
    localparam logic [2:0] K_REJECTED  = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] owner_tag;
        logic [15:0] key_tag;
        logic [63:0] write_value;
        logic [63:0] backing_value;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] out_owner;
        logic [15:0] out_key;
        logic [63:0] out_value;
        logic        last;
    } t_res;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture request, reset scan
        logic       scan;      // examine entry at scan index, advance
        logic       hit_upd;   // apply hit update
        logic       fill;      // fill victim
        logic       flush_ent; // invalidate entry at scan index
        logic       emit;      // drive a result
        logic [2:0] kind;
        logic       src_ent;   // result payload from entry register
        logic       last;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       scan_done;
        logic       hit;
        logic       owner_zero;
        logic [1:0] op;
        logic       victim_dirty;
        logic       ent_flush;  // current flush entry is selected
        logic       ent_dirty;
    } t_sts;
endpackage

>>> rtl/core/wblc_datapath.sv
// Entry storage, sequential scan and result payload for the tag cache.
// Depends on wblc_pkg.
`timescale 1ns / 1ps
module wblc_datapath #(
    parameter int ENTRIES    = wblc_pkg::ENTRIES_DEF,
    parameter int VALUE_BITS = wblc_pkg::VALUE_BITS_DEF,
    parameter int OWNER_BITS = wblc_pkg::OWNER_BITS_DEF,
    parameter int KEY_BITS   = wblc_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = wblc_pkg::COUNT_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wblc_pkg::t_req  i_req,
    input  wblc_pkg::t_cmd  i_cmd,
    output wblc_pkg::t_sts  o_sts,
    output wblc_pkg::t_res  o_res
);
    import wblc_pkg::*;
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0]    r_valid, r_dirty;
    logic [OWNER_BITS-1:0] r_own [ENTRIES];
    logic [KEY_BITS-1:0]   r_key [ENTRIES];
    logic [COUNT_BITS-1:0] r_uses [ENTRIES];
    logic [VALUE_BITS-1:0] r_mem [ENTRIES];

    logic [1:0]            r_op;
    logic [OWNER_BITS-1:0] r_rowner;
    logic [KEY_BITS-1:0]   r_rkey;
    logic [VALUE_BITS-1:0] r_wval, r_bval;
    logic [CW-1:0]         r_cnt;
    logic                  r_hit;
    logic [IW-1:0]         r_hidx, r_vidx;
    logic [COUNT_BITS-1:0] r_vcnt;
    // registered entry fields for writeback / read data
    logic [OWNER_BITS-1:0] r_eown;
    logic [KEY_BITS-1:0]   r_ekey;
    logic [VALUE_BITS-1:0] r_eval;

    logic [IW-1:0]         w_idx;
    logic [COUNT_BITS-1:0] w_c;
    logic                  w_match, w_sel;

    assign w_idx   = r_cnt[IW-1:0];
    assign w_c     = r_valid[w_idx] ? r_uses[w_idx] : '0;
    assign w_match = r_valid[w_idx] && r_own[w_idx] == r_rowner && r_key[w_idx] == r_rkey;
    assign w_sel   = r_valid[w_idx] && (r_op == OP_FLUSH_ALL || r_own[w_idx] == r_rowner);

    assign o_sts.scan_done    = (r_cnt == CW'(ENTRIES));
    assign o_sts.hit          = r_hit;
    assign o_sts.owner_zero   = (r_rowner == '0);
    assign o_sts.op           = r_op;
    assign o_sts.victim_dirty = r_valid[r_vidx] && r_dirty[r_vidx];
    assign o_sts.ent_flush    = w_sel;
    assign o_sts.ent_dirty    = r_dirty[w_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_cnt   <= '0;
            r_hit   <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_own[i]  <= '0;
                r_key[i]  <= '0;
                r_uses[i] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_op     <= i_req.op;
                r_rowner <= i_req.owner_tag[OWNER_BITS-1:0];
                r_rkey   <= i_req.key_tag[KEY_BITS-1:0];
                r_wval   <= i_req.write_value[VALUE_BITS-1:0];
                r_bval   <= i_req.backing_value[VALUE_BITS-1:0];
                r_cnt    <= '0;
                r_hit    <= 1'b0;
                r_vidx   <= '0;
                r_vcnt   <= '1;
                r_hidx   <= '0;
            end
            if (i_cmd.scan) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_match && !r_hit) begin
                    r_hit  <= 1'b1;
                    r_hidx <= w_idx;
                end
                if (r_cnt == '0 || w_c < r_vcnt) begin
                    r_vidx <= w_idx;
                    r_vcnt <= w_c;
                end
                r_eown <= r_own[w_idx];
                r_ekey <= r_key[w_idx];
                r_eval <= r_mem[w_idx];
            end
            if (i_cmd.hit_upd) begin
                if (r_uses[r_hidx] != '1) r_uses[r_hidx] <= r_uses[r_hidx] + 1'b1;
                if (r_op == OP_WRITE) begin
                    r_mem[r_hidx]   <= r_wval;
                    r_dirty[r_hidx] <= 1'b1;
                end else begin
                    r_eval <= r_mem[r_hidx];
                end
            end
            if (i_cmd.fill) begin
                r_valid[r_vidx] <= 1'b1;
                r_dirty[r_vidx] <= 1'b0;
                r_own[r_vidx]   <= r_rowner;
                r_key[r_vidx]   <= r_rkey;
                r_mem[r_vidx]   <= r_bval;
                r_uses[r_vidx]  <= COUNT_BITS'(1);
                r_eown <= r_own[r_vidx];
                r_ekey <= r_key[r_vidx];
                r_eval <= r_mem[r_vidx];
            end
            if (i_cmd.flush_ent) begin
                r_valid[w_idx] <= 1'b0;
                r_dirty[w_idx] <= 1'b0;
                r_uses[w_idx]  <= '0;
                r_own[w_idx]   <= '0;
                r_key[w_idx]   <= '0;
            end
        end
    end

    always_comb begin
        o_res = '0;
        if (i_cmd.emit) begin
            o_res.kind = i_cmd.kind;
            o_res.last = i_cmd.last;
            unique case (i_cmd.kind)
                K_WRITEBACK: begin
                    o_res.out_owner = 32'(r_eown);
                    o_res.out_key   = 16'(r_ekey);
                    o_res.out_value = 64'(r_eval);
                end
                K_READ_DATA: begin
                    o_res.out_owner = 32'(r_rowner);
                    o_res.out_key   = 16'(r_rkey);
                    o_res.out_value = i_cmd.src_ent ? 64'(r_eval) : 64'(r_bval);
                end
                K_WRITE_THR: begin
                    o_res.out_owner = 32'(r_rowner);
                    o_res.out_key   = 16'(r_rkey);
                    o_res.out_value = 64'(r_wval);
                end
                default: ;
            endcase
        end
    end
endmodule

>>> rtl/core/wblc_ctrl.sv
// Request sequencer for the tag cache.
// Depends on wblc_pkg.
`timescale 1ns / 1ps
module wblc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  wblc_pkg::t_sts i_sts,
    output wblc_pkg::t_cmd o_cmd,
    output logic           o_valid
);
    import wblc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DISP  = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_DEC   = 8'b0000_1000,
        S_FILL  = 8'b0001_0000,
        S_RDATA = 8'b0010_0000,
        S_FLUSH = 8'b0100_0000,
        S_HITO  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_busy = (r_state != S_IDLE);
    assign o_valid = o_cmd.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) n_state = S_DISP;
            end
            S_DISP: begin
                if (i_sts.op == OP_FLUSH_ALL) begin
                    n_state = S_FLUSH;
                end else if (i_sts.owner_zero) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_REJECTED;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_sts.op == OP_FLUSH_OWN) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_DEC;
                else o_cmd.scan = 1'b1;
            end
            S_DEC: begin
                if (i_sts.hit) begin
                    o_cmd.hit_upd = 1'b1;
                    if (i_sts.op == OP_WRITE) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = K_DONE;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_HITO;
                    end
                end else if (i_sts.op == OP_WRITE) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_WRITE_THR;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.fill = 1'b1;
                    n_state    = i_sts.victim_dirty ? S_FILL : S_RDATA;
                end
            end
            S_FILL: begin
                // old victim contents captured at fill
                o_cmd.emit = 1'b1;
                o_cmd.kind = K_WRITEBACK;
                n_state    = S_RDATA;
            end
            S_RDATA: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = K_READ_DATA;
                o_cmd.last = 1'b1;
                n_state    = S_IDLE;
            end
            S_HITO: begin
                o_cmd.emit    = 1'b1;
                o_cmd.kind    = K_READ_DATA;
                o_cmd.src_ent = 1'b1;
                o_cmd.last    = 1'b1;
                n_state       = S_IDLE;
            end
            S_FLUSH: begin
                // scan captures entry fields; a dirty match is written back
                // in the next cycle from that captured copy
                if (i_sts.scan_done) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_DONE;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.scan      = 1'b1;
                    o_cmd.flush_ent = i_sts.ent_flush;
                    if (i_sts.ent_flush && i_sts.ent_dirty) n_state = S_HITO;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // flush writeback: S_HITO entered from flush emits a writeback instead
        if (r_state == S_HITO && i_sts.op[1]) begin
            o_cmd.kind    = K_WRITEBACK;
            o_cmd.src_ent = 1'b0;
            o_cmd.last    = 1'b0;
            n_state       = S_FLUSH;
        end
    end
endmodule

>>> rtl/core/write_back_lfu_tag_cache_core.sv
// Top level of the write-back LFU tag cache.
// Depends on wblc_pkg, wblc_ctrl and wblc_datapath.
`timescale 1ns / 1ps
// Fully associative write-back cache with least-frequently-used replacement.
// A request is taken when start is high and busy low; results appear on
// o_res for one cycle each, flagged by o_valid, and cannot be stalled. The
// final result of a request has last set. Entries are examined one per cycle
// by a shared compare unit, a flush pausing for each dirty writeback. A request
// with owner zero is rejected, except a flush of all entries.
module write_back_lfu_tag_cache_core #(
    parameter int ENTRIES    = wblc_pkg::ENTRIES_DEF,
    parameter int VALUE_BITS = wblc_pkg::VALUE_BITS_DEF,
    parameter int OWNER_BITS = wblc_pkg::OWNER_BITS_DEF,
    parameter int KEY_BITS   = wblc_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = wblc_pkg::COUNT_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  wblc_pkg::t_req i_req,
    output logic           o_valid,
    output wblc_pkg::t_res o_res
);
    import wblc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    wblc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_valid(o_valid)
    );

    wblc_datapath #(
        .ENTRIES(ENTRIES), .VALUE_BITS(VALUE_BITS), .OWNER_BITS(OWNER_BITS),
        .KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_res(o_res)
    );

    // a request finishes with exactly one last result, which returns to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.last) |=> !busy) else $error("last without idle");
    // no result while idle
    a_no_idle_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !o_valid) else $error("result while idle");
    // a request is never accepted and answered in the same cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept not registered");
endmodule
